### sv/stack_register_vm_executor_top_macros.svh
// Assertion macros for the stack VM executor.
// Used by the top level; needs aclk and aresetn in the including scope.
`ifndef STACK_REGISTER_VM_EXECUTOR_TOP_MACROS_SVH
`define STACK_REGISTER_VM_EXECUTOR_TOP_MACROS_SVH

// Checked on every clock edge outside reset.
`define SVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SVM_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### sv/svm_pkg.sv
// Shared constants, opcodes and types for the stack VM executor.
// No dependencies; used by svm_div and stack_register_vm_executor_top.
package svm_pkg;

    localparam int NUM_REGS    = 16;
    localparam int STACK_DEPTH = 2048;
    localparam int CODE_DEPTH  = 512;

    localparam int DATA_W = 32;
    localparam int RF_AW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SA_W   = $clog2(STACK_DEPTH);
    localparam int ST_W   = 12;
    localparam int PC_W   = 10;
    localparam int FA_W   = 9;
    localparam int IDX_W  = 34;
    localparam int DIV_CW = $clog2(DATA_W) + 1;

    typedef enum logic [4:0] {
        OP_LIT   = 5'd1,
        OP_RTN   = 5'd2,
        OP_LOD   = 5'd3,
        OP_STO   = 5'd4,
        OP_CAL   = 5'd5,
        OP_INC   = 5'd6,
        OP_JMP   = 5'd7,
        OP_JPC   = 5'd8,
        OP_WRITE = 5'd9,
        OP_READ  = 5'd10,
        OP_HALT  = 5'd11,
        OP_NEG   = 5'd12,
        OP_ADD   = 5'd13,
        OP_SUB   = 5'd14,
        OP_MUL   = 5'd15,
        OP_DIV   = 5'd16,
        OP_ODD   = 5'd17,
        OP_MOD   = 5'd18,
        OP_EQL   = 5'd19,
        OP_NEQ   = 5'd20,
        OP_LSS   = 5'd21,
        OP_LEQ   = 5'd22,
        OP_GTR   = 5'd23,
        OP_GEQ   = 5'd24
    } opcode_t;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_DIV0  = 2'd1;
    localparam logic [1:0] FAULT_STACK = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

    // True when a signed index addresses an entry of the stack memory.
    function automatic logic in_stack(input logic signed [IDX_W-1:0] x);
        return !x[IDX_W-1] && (x[IDX_W-2:0] < (IDX_W-1)'(STACK_DEPTH));
    endfunction

endpackage

### sv/svm_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on svm_pkg for widths and the request and response structs.
module svm_div import svm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DATA_W:0]   shifted, trial;

    always_comb begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        if (!trial[DATA_W]) begin
            rem_next = trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(DATA_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### sv/stack_register_vm_executor_top.sv
// Top level of the stack VM executor: sequencer, register file, stack memory and divider.
// Depends on svm_pkg, svm_div and stack_register_vm_executor_top_macros.svh.
//
//  channel  direction  ports                                         word
//  s_       in         s_valid s_ready s_opcode .. s_read_value        one instruction
//  m_       out        m_valid m_ready m_fetch_address .. m_fault      one step result
//
// After reset the stack memory is cleared one entry a cycle, all STACK_DEPTH (2048)
// entries, and s_ready stays low while it is cleared.
// One instruction at a time. A halted step goes straight to the result; a plain
// instruction passes three register-file reads, execute and result. Each static-link
// hop adds a stack-memory read, a load a read, a store a write, a call four frame-slot
// writes, a return two reads, and divide and modulo wait for the divider.
// The result register lets the next word be accepted while a result is stalled.
`include "stack_register_vm_executor_top_macros.svh"

module stack_register_vm_executor_top import svm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_opcode,
    input  logic [3:0]         s_reg_sel,
    input  logic [3:0]         s_level,
    input  logic signed [15:0] s_operand_m,
    input  logic signed [31:0] s_read_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [8:0]         m_fetch_address,
    output logic               m_halted,
    output logic               m_print_valid,
    output logic [3:0]         m_print_reg,
    output logic signed [31:0] m_print_value,
    output logic [1:0]         m_fault
);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_RDA   = 14'b00000000000100,
        S_RDB   = 14'b00000000001000,
        S_RDR   = 14'b00000000010000,
        S_EXEC  = 14'b00000000100000,
        S_WALK  = 14'b00000001000000,
        S_WALKW = 14'b00000010000000,
        S_LODW  = 14'b00000100000000,
        S_CALW  = 14'b00001000000000,
        S_RTN1  = 14'b00010000000000,
        S_RTN2  = 14'b00100000000000,
        S_DIV   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]              op_reg, op_next;
    logic [3:0]              r_reg, r_next;
    logic [3:0]              l_reg, l_next;
    logic [15:0]             m_reg, m_next;
    logic [DATA_W-1:0]       rdv_reg, rdv_next;
    logic [DATA_W-1:0]       a_reg, a_next;
    logic [DATA_W-1:0]       b_reg, b_next;
    logic [DATA_W-1:0]       rv_reg, rv_next;
    logic [PC_W-1:0]         pc_reg, pc_next;
    logic [ST_W-1:0]         st_reg, st_next;
    logic [ST_W-1:0]         fb_reg, fb_next;
    logic [ST_W-1:0]         fbtmp_reg, fbtmp_next;
    logic                    halt_reg, halt_next;
    logic signed [IDX_W-1:0] cur_reg, cur_next;
    logic [3:0]              hops_reg, hops_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic [SA_W-1:0]         clr_reg, clr_next;
    logic [1:0]              fault_reg, fault_next;
    logic                    pv_reg, pv_next;
    logic [3:0]              preg_reg, preg_next;
    logic [DATA_W-1:0]       pval_reg, pval_next;

    logic                    mv_reg, mv_next;
    logic [FA_W-1:0]         ofa_reg, ofa_next;
    logic                    ohalt_reg, ohalt_next;
    logic                    opv_reg, opv_next;
    logic [3:0]              opreg_reg, opreg_next;
    logic [DATA_W-1:0]       opval_reg, opval_next;
    logic [1:0]              ofault_reg, ofault_next;

    // Register file: one write and one read port, read data registered.
    logic [DATA_W-1:0]   rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid;
    logic [DATA_W-1:0]   rf_rdata;
    logic [15:0]         rf_raddr;
    logic                rf_rok;
    logic                rf_we;
    logic [3:0]          rf_waddr;
    logic                rf_wok;
    logic [DATA_W-1:0]   rf_wdata;

    // Stack memory: single port, read data registered.
    logic [DATA_W-1:0] sm_mem [STACK_DEPTH];
    logic [DATA_W-1:0] sm_rdata;
    logic              sm_we;
    logic [SA_W-1:0]   sm_addr;
    logic [DATA_W-1:0] sm_wdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                    halted_now;
    logic signed [IDX_W-1:0] m_sx, st_ext, fb_ext;
    logic signed [IDX_W-1:0] st_p4, st_pm, fb_p2, fb_p3, cur_p1, cur_pm, cal_slot;
    logic [DATA_W-1:0]       m_32, a_mag, b_mag, prod, quo_s, rem_s;
    logic signed [DATA_W-1:0] sa, sb;

    svm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign rf_rok = (rf_raddr < 16'(NUM_REGS));
    assign rf_wok = (rf_waddr < 4'(NUM_REGS > 15 ? 15 : NUM_REGS)) || (NUM_REGS > 15);

    always_ff @(posedge aclk) begin
        if (rf_we && rf_wok) begin
            rf_mem[rf_waddr[RF_AW-1:0]] <= rf_wdata;
        end
        if (rf_rok && rf_valid[rf_raddr[RF_AW-1:0]]) begin
            rf_rdata <= rf_mem[rf_raddr[RF_AW-1:0]];
        end else begin
            rf_rdata <= '0;
        end
    end

    // A register that was never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_valid <= '0;
        end else if (rf_we && rf_wok) begin
            rf_valid[rf_waddr[RF_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (sm_we) begin
            sm_mem[sm_addr] <= sm_wdata;
        end
        sm_rdata <= sm_mem[sm_addr];
    end

    assign halted_now = halt_reg || (pc_reg >= PC_W'(CODE_DEPTH));
    assign m_32   = {{(DATA_W-16){m_reg[15]}}, m_reg};
    assign m_sx   = {{(IDX_W-16){m_reg[15]}}, m_reg};
    assign st_ext = {{(IDX_W-ST_W){1'b0}}, st_reg};
    assign fb_ext = {{(IDX_W-ST_W){1'b0}}, fb_reg};
    assign st_p4  = st_ext + IDX_W'(4);
    assign st_pm  = st_ext + m_sx;
    assign fb_p2  = fb_ext + IDX_W'(2);
    assign fb_p3  = fb_ext + IDX_W'(3);
    assign cur_p1 = cur_reg + IDX_W'(1);
    assign cur_pm = cur_reg + m_sx;
    assign cal_slot = st_ext + IDX_W'(1) + {{(IDX_W-2){1'b0}}, cnt_reg};
    assign sa     = a_reg;
    assign sb     = b_reg;
    assign a_mag  = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
    assign b_mag  = b_reg[DATA_W-1] ? (DATA_W'(0) - b_reg) : b_reg;
    assign prod   = a_reg * b_reg;
    assign quo_s  = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) ?
                    (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;
    assign rem_s  = a_reg[DATA_W-1] ? (DATA_W'(0) - div_rsp.remainder) : div_rsp.remainder;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        r_next      = r_reg;
        l_next      = l_reg;
        m_next      = m_reg;
        rdv_next    = rdv_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rv_next     = rv_reg;
        pc_next     = pc_reg;
        st_next     = st_reg;
        fb_next     = fb_reg;
        fbtmp_next  = fbtmp_reg;
        halt_next   = halt_reg;
        cur_next    = cur_reg;
        hops_next   = hops_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        fault_next  = fault_reg;
        pv_next     = pv_reg;
        preg_next   = preg_reg;
        pval_next   = pval_reg;
        mv_next     = mv_reg && !m_ready;
        ofa_next    = ofa_reg;
        ohalt_next  = ohalt_reg;
        opv_next    = opv_reg;
        opreg_next  = opreg_reg;
        opval_next  = opval_reg;
        ofault_next = ofault_reg;
        rf_raddr    = {12'd0, l_reg};
        rf_we       = 1'b0;
        rf_waddr    = r_reg;
        rf_wdata    = '0;
        sm_we       = 1'b0;
        sm_addr     = clr_reg;
        sm_wdata    = '0;
        div_req.start    = 1'b0;
        div_req.dividend = a_mag;
        div_req.divisor  = b_mag;

        unique case (state_reg)
            S_CLEAR: begin
                sm_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SA_W'(STACK_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    r_next     = s_reg_sel;
                    l_next     = s_level;
                    m_next     = s_operand_m;
                    rdv_next   = s_read_value;
                    fault_next = FAULT_NONE;
                    pv_next    = 1'b0;
                    preg_next  = '0;
                    pval_next  = '0;
                    rf_raddr   = {12'd0, s_level};
                    if (halted_now) begin
                        state_next = S_DONE;
                    end else begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA: begin
                a_next     = rf_rdata;
                rf_raddr   = m_reg;
                state_next = S_RDB;
            end
            S_RDB: begin
                b_next     = rf_rdata;
                rf_raddr   = {12'd0, r_reg};
                state_next = S_RDR;
            end
            S_RDR: begin
                rv_next    = rf_rdata;
                cur_next   = fb_ext;
                hops_next  = l_reg;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_LIT: begin
                        rf_we    = 1'b1;
                        rf_wdata = m_32;
                    end
                    OP_RTN: begin
                        sm_addr = fb_p2[SA_W-1:0];
                        if (fb_reg == '0 || !in_stack(fb_p3)) begin
                            fault_next = FAULT_STACK;
                        end else begin
                            state_next = S_RTN1;
                        end
                    end
                    OP_LOD, OP_STO: begin
                        state_next = S_WALK;
                    end
                    OP_CAL: begin
                        if (!in_stack(st_p4)) begin
                            fault_next = FAULT_STACK;
                        end else begin
                            state_next = S_WALK;
                        end
                    end
                    OP_INC: begin
                        if (!in_stack(st_pm)) begin
                            fault_next = FAULT_STACK;
                        end else begin
                            st_next = st_pm[ST_W-1:0];
                        end
                    end
                    OP_JMP: begin
                        pc_next = m_reg[PC_W-1:0];
                    end
                    OP_JPC: begin
                        if (rv_reg == '0) begin
                            pc_next = m_reg[PC_W-1:0];
                        end
                    end
                    OP_WRITE: begin
                        pv_next   = 1'b1;
                        preg_next = r_reg;
                        pval_next = rv_reg;
                    end
                    OP_READ: begin
                        rf_we    = 1'b1;
                        rf_wdata = rdv_reg;
                    end
                    OP_HALT: begin
                        halt_next = 1'b1;
                    end
                    OP_NEG: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(0) - a_reg;
                    end
                    OP_ADD: begin
                        rf_we    = 1'b1;
                        rf_wdata = a_reg + b_reg;
                    end
                    OP_SUB: begin
                        rf_we    = 1'b1;
                        rf_wdata = a_reg - b_reg;
                    end
                    OP_MUL: begin
                        rf_we    = 1'b1;
                        rf_wdata = prod;
                    end
                    OP_DIV, OP_MOD: begin
                        if (b_reg == '0) begin
                            fault_next = FAULT_DIV0;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    OP_ODD: begin
                        rf_we = 1'b1;
                        if (!rv_reg[0]) begin
                            rf_wdata = '0;
                        end else if (rv_reg[DATA_W-1]) begin
                            rf_wdata = '1;
                        end else begin
                            rf_wdata = DATA_W'(1);
                        end
                    end
                    OP_EQL: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa == sb);
                    end
                    OP_NEQ: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa != sb);
                    end
                    OP_LSS: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa < sb);
                    end
                    OP_LEQ: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa <= sb);
                    end
                    OP_GTR: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa > sb);
                    end
                    OP_GEQ: begin
                        rf_we    = 1'b1;
                        rf_wdata = DATA_W'(sa >= sb);
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                state_next = S_DONE;
                if (hops_reg != '0) begin
                    sm_addr = cur_p1[SA_W-1:0];
                    if (!in_stack(cur_p1)) begin
                        fault_next = FAULT_STACK;
                    end else begin
                        state_next = S_WALKW;
                    end
                end else if (op_reg == OP_CAL) begin
                    cnt_next   = '0;
                    state_next = S_CALW;
                end else begin
                    sm_addr  = cur_pm[SA_W-1:0];
                    sm_wdata = rv_reg;
                    if (!in_stack(cur_pm)) begin
                        fault_next = FAULT_STACK;
                    end else if (op_reg == OP_LOD) begin
                        state_next = S_LODW;
                    end else begin
                        sm_we = 1'b1;
                    end
                end
            end
            S_WALKW: begin
                cur_next   = {{(IDX_W-DATA_W){sm_rdata[DATA_W-1]}}, sm_rdata};
                hops_next  = hops_reg - 1'b1;
                state_next = S_WALK;
            end
            S_LODW: begin
                rf_we      = 1'b1;
                rf_wdata   = sm_rdata;
                state_next = S_DONE;
            end
            S_CALW: begin
                // Frame slots above the stack top: zero, static link, old base, return.
                sm_we    = 1'b1;
                sm_addr  = cal_slot[SA_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    2'd0:    sm_wdata = '0;
                    2'd1:    sm_wdata = cur_reg[DATA_W-1:0];
                    2'd2:    sm_wdata = {{(DATA_W-ST_W){1'b0}}, fb_reg};
                    default: sm_wdata = {{(DATA_W-PC_W){1'b0}}, pc_reg};
                endcase
                if (cnt_reg == 2'd3) begin
                    fb_next    = st_reg + 1'b1;
                    pc_next    = m_reg[PC_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_RTN1: begin
                fbtmp_next = sm_rdata[ST_W-1:0];
                sm_addr    = fb_p3[SA_W-1:0];
                state_next = S_RTN2;
            end
            S_RTN2: begin
                pc_next    = sm_rdata[PC_W-1:0];
                st_next    = fb_reg - 1'b1;
                fb_next    = fbtmp_reg;
                state_next = S_DONE;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    rf_we      = 1'b1;
                    rf_wdata   = (op_reg == OP_DIV) ? quo_s : rem_s;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    ofa_next    = pc_reg[FA_W-1:0];
                    ohalt_next  = halted_now;
                    opv_next    = pv_reg;
                    opreg_next  = preg_reg;
                    opval_next  = pval_reg;
                    ofault_next = fault_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            st_reg    <= '0;
            fb_reg    <= ST_W'(1);
            halt_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
            hops_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            st_reg    <= st_next;
            fb_reg    <= fb_next;
            halt_reg  <= halt_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
            hops_reg  <= hops_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        r_reg      <= r_next;
        l_reg      <= l_next;
        m_reg      <= m_next;
        rdv_reg    <= rdv_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rv_reg     <= rv_next;
        fbtmp_reg  <= fbtmp_next;
        cur_reg    <= cur_next;
        fault_reg  <= fault_next;
        pv_reg     <= pv_next;
        preg_reg   <= preg_next;
        pval_reg   <= pval_next;
        ofa_reg    <= ofa_next;
        ohalt_reg  <= ohalt_next;
        opv_reg    <= opv_next;
        opreg_reg  <= opreg_next;
        opval_reg  <= opval_next;
        ofault_reg <= ofault_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = mv_reg;
    assign m_fetch_address = ofa_reg;
    assign m_halted        = ohalt_reg;
    assign m_print_valid   = opv_reg;
    assign m_print_reg     = opreg_reg;
    assign m_print_value   = opval_reg;
    assign m_fault         = ofault_reg;

    `SVM_ASSERT(a_clear_blocks_input, (state_reg == S_CLEAR) |-> !s_ready, "word accepted during stack clear")
    `SVM_ASSERT(a_print_no_fault, (m_valid && m_print_valid) |-> (m_fault == FAULT_NONE), "print with fault")
    `SVM_ASSERT(a_fault_code, m_valid |-> (m_fault == FAULT_NONE || m_fault == FAULT_DIV0 || m_fault == FAULT_STACK), "bad fault code")
    `SVM_ASSERT(a_div_owner, div_rsp.busy |-> (state_reg == S_DIV), "divider busy outside divide state")
    `SVM_ASSERT_NR(a_reset_clear, !aresetn |=> (state_reg == S_CLEAR), "reset did not start stack clear")

endmodule
